/* rtl/bfa_pkg.sv */
// Shared types, constants and state codes for the bitmap frame allocator.
`timescale 1ns / 1ps

package bfa_pkg;

  localparam int unsigned MAX_FRAMES_DEF = 4096;
  localparam int unsigned WORD_BITS_DEF  = 32;
  localparam int unsigned FRAME_W        = 12;
  localparam int unsigned COUNT_W        = 13;
  localparam logic [COUNT_W-1:0] COUNT_RST = 13'd4096;
  // Words summarised per leaf of the free-word search tree
  localparam int unsigned GROUP_WORDS    = 8;
  localparam int unsigned GLOW_W         = $clog2(GROUP_WORDS);

  typedef enum logic [0:0] {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } opcode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GROUP,
    ST_SELECT,
    ST_READ,
    ST_COMMIT
  } state_e;

  typedef struct packed {
    logic latch;    // capture the request beat
    logic grp;      // register per-group search summary
    logic sel;      // pick the word, read it
    logic rd_free;  // read the word of the frame being freed
    logic commit;   // modify, write back, register the result
  } cmd_t;

  typedef struct packed {
    logic need_search;  // allocate with an empty entry
    logic need_rmw;     // free of a nonzero frame inside the bitmap
  } sts_t;

endpackage

/* rtl/bfa_ctrl.sv */
// Sequencing state machine of the bitmap frame allocator.
`timescale 1ns / 1ps

module bfa_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  bfa_pkg::sts_t sts_i,
  output bfa_pkg::cmd_t cmd_o
);
  import bfa_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    case (state_q)
      ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.latch = 1'b1;
          if (sts_i.need_search) begin
            state_d = ST_GROUP;
          end else if (sts_i.need_rmw) begin
            state_d = ST_READ;
          end else begin
            state_d = ST_COMMIT;
          end
        end
      end
      ST_GROUP: begin
        cmd_o.grp = 1'b1;
        state_d   = ST_SELECT;
      end
      ST_SELECT: begin
        cmd_o.sel = 1'b1;
        state_d   = ST_COMMIT;
      end
      ST_READ: begin
        cmd_o.rd_free = 1'b1;
        state_d       = ST_COMMIT;
      end
      ST_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  a_commit_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> (state_q == ST_IDLE))
    else $error("commit not followed by idle");

  a_search_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && sts_i.need_search) |=> (state_q == ST_GROUP))
    else $error("search request did not enter group stage");

endmodule

/* rtl/bfa_datapath.sv */
// Bitmap storage, free-word search, bit search and result registers.
`timescale 1ns / 1ps

module bfa_datapath #(
  parameter int unsigned MAX_FRAMES = bfa_pkg::MAX_FRAMES_DEF,
  parameter int unsigned WORD_BITS  = bfa_pkg::WORD_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [bfa_pkg::COUNT_W-1:0] cfg_wdata_i,
  input  logic                        opcode_i,
  input  logic [bfa_pkg::FRAME_W-1:0] entry_frame_i,
  input  logic                        want_kernel_i,
  input  logic                        want_writable_i,
  input  bfa_pkg::cmd_t               cmd_i,
  output bfa_pkg::sts_t               sts_o,
  output logic                        done_o,
  output logic [bfa_pkg::FRAME_W-1:0] result_frame_o,
  output logic                        present_bit_o,
  output logic                        writable_bit_o,
  output logic                        user_bit_o,
  output logic                        allocated_o,
  output logic                        full_res_o
);
  import bfa_pkg::*;

  // Word width is taken as a power of two: frame to word is a shift.
  localparam int unsigned NUM_WORDS  = MAX_FRAMES / WORD_BITS;
  localparam int unsigned WORD_LOG   = $clog2(WORD_BITS);
  localparam int unsigned WIDX_W     = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int unsigned NUM_GROUPS = (NUM_WORDS + GROUP_WORDS - 1) / GROUP_WORDS;

  // Config and request
  logic [COUNT_W-1:0] frame_count_q;
  opcode_e            op_q;
  logic [FRAME_W-1:0] entry_q;
  logic               kern_q;
  logic               wr_q;

  // Bitmap memory with per-word valid and full flags
  logic [WORD_BITS-1:0] mem [NUM_WORDS];
  logic [NUM_WORDS-1:0] wvalid_q;
  logic [NUM_WORDS-1:0] full_q;

  // Search tree
  logic [NUM_GROUPS*GROUP_WORDS-1:0] cand;
  logic [31:0]                       cnt_ext;
  logic [31:0]                       lim;
  logic [NUM_GROUPS-1:0]             grp_any_d, grp_any_q;
  logic [GLOW_W-1:0]                 grp_low_d [NUM_GROUPS];
  logic [GLOW_W-1:0]                 grp_low_q [NUM_GROUPS];
  logic                              sel_found;
  logic [WIDX_W-1:0]                 sel_idx;

  // Read stage
  logic                 rd_en;
  logic [WIDX_W-1:0]    rd_addr;
  logic [WIDX_W-1:0]    free_widx;
  logic [WIDX_W-1:0]    widx_q;
  logic                 found_q;
  logic [WORD_BITS-1:0] rdata_q;
  logic                 rvalid_q;

  // Commit stage
  logic [WORD_BITS-1:0] word;
  logic [WORD_LOG-1:0]  abit;
  logic [WORD_LOG-1:0]  fbit;
  logic [WORD_BITS-1:0] new_word;
  logic                 alloc_hit;
  logic                 alloc_echo;
  logic                 alloc_full;
  logic                 free_ok;
  logic                 wr_en;
  logic [FRAME_W-1:0]   res_frame_d;

  // Result registers
  logic               done_q;
  logic [FRAME_W-1:0] res_frame_q;
  logic               present_q, writable_q, user_q, allocated_q, full_res_q;

  // Request decode for the controller
  always_comb begin
    sts_o.need_search = (opcode_i == OP_ALLOC) && (entry_frame_i == '0);
    sts_o.need_rmw    = (opcode_i == OP_FREE) && (entry_frame_i != '0) &&
                        (32'(entry_frame_i) < 32'(MAX_FRAMES));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_count_q <= COUNT_RST;
    end else if (cfg_we_i) begin
      frame_count_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q    <= opcode_e'(opcode_i);
      entry_q <= entry_frame_i;
      kern_q  <= want_kernel_i;
      wr_q    <= want_writable_i;
    end
  end

  // Candidate words: not full and wholly inside the clamped frame count
  always_comb begin
    cnt_ext = 32'(frame_count_q);
    lim     = (cnt_ext > 32'(MAX_FRAMES)) ? 32'(MAX_FRAMES) : cnt_ext;
    cand    = '0;
    for (int i = 0; i < NUM_WORDS; i++) begin
      cand[i] = !full_q[i] && (lim >= 32'((i + 1) * WORD_BITS));
    end
  end

  always_comb begin
    for (int g = 0; g < NUM_GROUPS; g++) begin
      grp_any_d[g] = |cand[g*GROUP_WORDS +: GROUP_WORDS];
      grp_low_d[g] = '0;
      for (int j = GROUP_WORDS - 1; j >= 0; j--) begin
        if (cand[g*GROUP_WORDS + j]) begin
          grp_low_d[g] = GLOW_W'(j);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.grp) begin
      grp_any_q <= grp_any_d;
      grp_low_q <= grp_low_d;
    end
  end

  always_comb begin
    sel_found = 1'b0;
    sel_idx   = '0;
    for (int g = NUM_GROUPS - 1; g >= 0; g--) begin
      if (grp_any_q[g]) begin
        sel_found = 1'b1;
        sel_idx   = WIDX_W'(g * GROUP_WORDS + int'(grp_low_q[g]));
      end
    end
  end

  // Read port: found word on allocate, frame's word on free
  assign free_widx = WIDX_W'(entry_q >> WORD_LOG);
  assign rd_en     = cmd_i.sel || cmd_i.rd_free;
  assign rd_addr   = cmd_i.rd_free ? free_widx : sel_idx;

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      widx_q   <= rd_addr;
      found_q  <= cmd_i.rd_free ? 1'b1 : sel_found;
      rdata_q  <= mem[rd_addr];
      rvalid_q <= wvalid_q[rd_addr];
    end
  end

  // Modify: lowest clear bit on allocate, frame's bit on free
  always_comb begin
    word = rvalid_q ? rdata_q : '0;
    abit = '0;
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      if (!word[j]) begin
        abit = WORD_LOG'(j);
      end
    end
    fbit       = entry_q[WORD_LOG-1:0];
    alloc_echo = (op_q == OP_ALLOC) && (entry_q != '0);
    alloc_hit  = (op_q == OP_ALLOC) && (entry_q == '0) && found_q;
    alloc_full = (op_q == OP_ALLOC) && (entry_q == '0) && !found_q;
    free_ok    = (op_q == OP_FREE) && (entry_q != '0) &&
                 (32'(entry_q) < 32'(MAX_FRAMES));
    if (op_q == OP_ALLOC) begin
      new_word = word | (WORD_BITS'(1) << abit);
    end else begin
      new_word = word & ~(WORD_BITS'(1) << fbit);
    end
    wr_en = cmd_i.commit && (alloc_hit || free_ok);
    if (alloc_echo) begin
      res_frame_d = entry_q;
    end else if (alloc_hit) begin
      res_frame_d = FRAME_W'({widx_q, abit});
    end else begin
      res_frame_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[widx_q] <= new_word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wvalid_q <= '0;
      full_q   <= '0;
    end else if (wr_en) begin
      wvalid_q[widx_q] <= 1'b1;
      full_q[widx_q]   <= &new_word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.commit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      res_frame_q <= res_frame_d;
      present_q   <= alloc_hit;
      writable_q  <= alloc_hit && wr_q;
      user_q      <= alloc_hit && !kern_q;
      allocated_q <= alloc_hit;
      full_res_q  <= alloc_full;
    end
  end

  assign done_o         = done_q;
  assign result_frame_o = res_frame_q;
  assign present_bit_o  = present_q;
  assign writable_bit_o = writable_q;
  assign user_bit_o     = user_q;
  assign allocated_o    = allocated_q;
  assign full_res_o     = full_res_q;

  a_pick_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && alloc_hit) |-> !word[abit])
    else $error("allocation picked a frame already in use");

  a_sel_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.sel && sel_found) |-> !full_q[sel_idx])
    else $error("search selected a full word");

  a_write_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |=> wvalid_q[$past(widx_q)])
    else $error("written word not marked valid");

endmodule

/* rtl/bitmap_frame_allocator.sv */
// Top level of the first-fit bitmap page frame allocator.
`timescale 1ns / 1ps
// An allocate that searches steps through group, select and commit, a free of
//   a frame in the bitmap through read and commit, others straight to commit;
//   the result registers load at commit. A new request is taken only in idle,
//   one at a time over the shared bitmap port and two-level free-word search.
// Results cannot be stalled: each one is shown for a single cycle.
// Reset: asynchronous, every frame free at once through per-word valid flags.

module bitmap_frame_allocator #(
  parameter int unsigned MAX_FRAMES = bfa_pkg::MAX_FRAMES_DEF,
  parameter int unsigned WORD_BITS  = bfa_pkg::WORD_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Configuration: frame count
  input  logic                        cfg_we_i,
  input  logic [bfa_pkg::COUNT_W-1:0] cfg_wdata_i,
  // Request beat
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic                        opcode_i,
  input  logic [bfa_pkg::FRAME_W-1:0] entry_frame_i,
  input  logic                        want_kernel_i,
  input  logic                        want_writable_i,
  // Result beat
  output logic                        done_o,
  output logic [bfa_pkg::FRAME_W-1:0] result_frame_o,
  output logic                        present_bit_o,
  output logic                        writable_bit_o,
  output logic                        user_bit_o,
  output logic                        allocated_o,
  output logic                        full_res_o
);
  import bfa_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Controller: steps each request through search or read as needed, then commit
  bfa_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .sts_i   (sts),
    .cmd_o   (cmd)
  );

  // Datapath: bitmap memory, full summary, encoders and result registers
  bfa_datapath #(
    .MAX_FRAMES (MAX_FRAMES),
    .WORD_BITS  (WORD_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .opcode_i        (opcode_i),
    .entry_frame_i   (entry_frame_i),
    .want_kernel_i   (want_kernel_i),
    .want_writable_i (want_writable_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .done_o          (done_o),
    .result_frame_o  (result_frame_o),
    .present_bit_o   (present_bit_o),
    .writable_bit_o  (writable_bit_o),
    .user_bit_o      (user_bit_o),
    .allocated_o     (allocated_o),
    .full_res_o      (full_res_o)
  );

endmodule

/* tb/frame_alloc_check.sv */
// Checker for the bitmap frame allocator: predicts each result beat and compares it.
`timescale 1ns / 1ps

module frame_alloc_check (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [bfa_pkg::COUNT_W-1:0] cfg_wdata_i,
  input  logic                        start_i,
  input  logic                        busy_i,
  input  logic                        opcode_i,
  input  logic [bfa_pkg::FRAME_W-1:0] entry_frame_i,
  input  logic                        want_kernel_i,
  input  logic                        want_writable_i,
  input  logic                        done_i,
  input  logic [bfa_pkg::FRAME_W-1:0] result_frame_i,
  input  logic                        present_bit_i,
  input  logic                        writable_bit_i,
  input  logic                        user_bit_i,
  input  logic                        allocated_i,
  input  logic                        full_res_i,
  output int                          pending_o,
  output int                          fail_count_o
);
  import bfa_pkg::*;

  localparam int unsigned NUM_WORDS = MAX_FRAMES_DEF / WORD_BITS_DEF;

  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic               present;
    logic               writable;
    logic               user;
    logic               alloc;
    logic               full;
  } page_result_t;

  logic [WORD_BITS_DEF-1:0] used_map [NUM_WORDS];
  logic [COUNT_W-1:0]       frame_limit;
  page_result_t             grants_q [$];
  int                       mismatches = 0;

  assign fail_count_o = mismatches;

  // Apply one request to the frame map and return the page entry it yields
  function automatic page_result_t serve_request(opcode_e op, logic [FRAME_W-1:0] entry,
                                                 logic kern, logic wr);
    page_result_t res;
    int unsigned  limit;
    int unsigned  words;
    int unsigned  idx;
    int unsigned  w;
    int unsigned  b;
    bit           found;
    res = '0;
    if (op == OP_FREE) begin
      if (entry != '0 && 32'(entry) < MAX_FRAMES_DEF)
        used_map[entry / WORD_BITS_DEF][entry % WORD_BITS_DEF] = 1'b0;
      return res;
    end
    if (entry != '0) begin
      res.frame = entry;
      return res;
    end
    limit = (32'(frame_limit) > MAX_FRAMES_DEF) ? MAX_FRAMES_DEF : 32'(frame_limit);
    words = limit / WORD_BITS_DEF;
    found = 1'b0;
    idx   = 0;
    for (w = 0; w < words && !found; w++) begin
      for (b = 0; b < WORD_BITS_DEF && !found; b++) begin
        if (!used_map[w][b]) begin
          found = 1'b1;
          idx   = w * WORD_BITS_DEF + b;
        end
      end
    end
    if (!found) begin
      res.full = 1'b1;
      return res;
    end
    used_map[idx / WORD_BITS_DEF][idx % WORD_BITS_DEF] = 1'b1;
    res.frame    = FRAME_W'(idx);
    res.present  = 1'b1;
    res.writable = wr;
    res.user     = ~kern;
    res.alloc    = 1'b1;
    return res;
  endfunction

  function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    page_result_t head;
    if (!rst_ni) begin
      foreach (used_map[i]) used_map[i] = '0;
      frame_limit = COUNT_RST;
      grants_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) frame_limit = cfg_wdata_i;
      if (done_i) begin
        if (grants_q.size() == 0) begin
          $error("result beat with nothing outstanding: frame %0d", result_frame_i);
          mismatches++;
        end else begin
          head = grants_q.pop_front();
          check_field("result_frame", 32'(head.frame), 32'(result_frame_i));
          check_field("present_bit", 32'(head.present), 32'(present_bit_i));
          check_field("writable_bit", 32'(head.writable), 32'(writable_bit_i));
          check_field("user_bit", 32'(head.user), 32'(user_bit_i));
          check_field("allocated", 32'(head.alloc), 32'(allocated_i));
          check_field("full_res", 32'(head.full), 32'(full_res_i));
        end
      end
      if (start_i && !busy_i)
        grants_q.push_back(serve_request(opcode_e'(opcode_i), entry_frame_i,
                                         want_kernel_i, want_writable_i));
      pending_o <= grants_q.size();
    end
  end

endmodule

/* tb/tb_top.sv */
// Testbench top for the bitmap frame allocator: stimulus, idling and the verdict.
`timescale 1ns / 1ps

module tb_top;
  import bfa_pkg::*;

  localparam int unsigned PHASES         = 8;
  localparam int unsigned BEATS_PER_PHASE = 200;

  // Clock, reset and block inputs; every input starts at a known value
  logic               clk           = 1'b0;
  logic               rst_n         = 1'b0;
  logic               cfg_we        = 1'b0;
  logic [COUNT_W-1:0] cfg_wdata     = COUNT_RST;
  logic               start         = 1'b0;
  logic               opcode        = OP_ALLOC;
  logic [FRAME_W-1:0] entry_frame   = '0;
  logic               want_kernel   = 1'b0;
  logic               want_writable = 1'b0;

  logic               busy;
  logic               done;
  logic [FRAME_W-1:0] result_frame;
  logic               present_bit;
  logic               writable_bit;
  logic               user_bit;
  logic               allocated;
  logic               full_res;

  int                 pending;
  int                 fails;

  // Stimulus-side copy of the frame count, used only to aim frees at live frames
  logic [COUNT_W-1:0] frame_limit = COUNT_RST;
  bit                 idling_on   = 1'b1;

  logic [COUNT_W-1:0] phase_counts [PHASES] =
    '{13'd32, 13'd8191, 13'd64, 13'd4096, 13'd100, 13'd0, 13'd0, 13'd33};

  always #2 clk = ~clk;

  bitmap_frame_allocator dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .start_i        (start),
    .busy_o         (busy),
    .opcode_i       (opcode),
    .entry_frame_i  (entry_frame),
    .want_kernel_i  (want_kernel),
    .want_writable_i(want_writable),
    .done_o         (done),
    .result_frame_o (result_frame),
    .present_bit_o  (present_bit),
    .writable_bit_o (writable_bit),
    .user_bit_o     (user_bit),
    .allocated_o    (allocated),
    .full_res_o     (full_res)
  );

  frame_alloc_check u_alloc_check (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .start_i        (start),
    .busy_i         (busy),
    .opcode_i       (opcode),
    .entry_frame_i  (entry_frame),
    .want_kernel_i  (want_kernel),
    .want_writable_i(want_writable),
    .done_i         (done),
    .result_frame_i (result_frame),
    .present_bit_i  (present_bit),
    .writable_bit_i (writable_bit),
    .user_bit_i     (user_bit),
    .allocated_i    (allocated),
    .full_res_i     (full_res),
    .pending_o      (pending),
    .fail_count_o   (fails)
  );

  // Hold one request beat until the block takes it, then maybe idle a burst.
  // Busy is read straight after the edge, so it is the value the edge saw.
  task automatic issue(input opcode_e op, input logic [FRAME_W-1:0] ef,
                       input logic kern, input logic wr);
    start         <= 1'b1;
    opcode        <= op;
    entry_frame   <= ef;
    want_kernel   <= kern;
    want_writable <= wr;
    do @(posedge clk); while (busy);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  // Drop start and wait until every outstanding result beat has been seen
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Write the frame count while the block is idle
  task automatic set_frame_count(input logic [COUNT_W-1:0] value);
    drain();
    cfg_we      <= 1'b1;
    cfg_wdata   <= value;
    frame_limit  = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly allocations from an empty entry, so small maps fill up and report
  // full; frees mostly land inside the searched words (plus one spare word)
  // so that they hit frames that are actually in use.
  task automatic random_beat();
    int unsigned        pick;
    int unsigned        span;
    logic [FRAME_W-1:0] near_frame;
    pick = $urandom_range(0, 99);
    span = (32'(frame_limit) > MAX_FRAMES_DEF) ? MAX_FRAMES_DEF : 32'(frame_limit);
    span = span + WORD_BITS_DEF;
    if (span > MAX_FRAMES_DEF) span = MAX_FRAMES_DEF;
    near_frame = FRAME_W'($urandom_range(0, span - 1));
    if (pick < 60)
      issue(OP_ALLOC, '0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    else if (pick < 68)
      issue(OP_ALLOC, FRAME_W'($urandom_range(1, 4095)), 1'($urandom_range(0, 1)),
            1'($urandom_range(0, 1)));
    else if (pick < 92)
      issue(OP_FREE, near_frame, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    else
      issue(OP_FREE, FRAME_W'($urandom), 1'($urandom_range(0, 1)),
            1'($urandom_range(0, 1)));
  endtask

  // Watchdog: far beyond the slowest legal run
  initial begin : watchdog
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: frame zero handed out first, entries that already hold a frame
    issue(OP_ALLOC, '0, 1'b0, 1'b1);
    issue(OP_ALLOC, '0, 1'b1, 1'b0);
    issue(OP_ALLOC, 12'hFFF, 1'b1, 1'b1);
    issue(OP_ALLOC, 12'h001, 1'b0, 1'b0);
    // Free of frame zero leaves it in use; free of frame one releases it
    issue(OP_FREE, '0, 1'b1, 1'b1);
    issue(OP_FREE, 12'h001, 1'b0, 1'b1);
    issue(OP_ALLOC, '0, 1'b0, 1'b0);
    // Frees of frames never taken, top of the range and alternating bits
    issue(OP_FREE, 12'hFFF, 1'b0, 1'b0);
    issue(OP_FREE, 12'hAAA, 1'b1, 1'b0);
    issue(OP_FREE, 12'h555, 1'b0, 1'b1);
    issue(OP_ALLOC, '0, 1'b1, 1'b1);
    // Frame count below one word: nothing is searched, so full
    set_frame_count(13'd0);
    issue(OP_ALLOC, '0, 1'b0, 1'b1);
    set_frame_count(13'd31);
    issue(OP_ALLOC, '0, 1'b1, 1'b0);
    // Exactly one word, then a free inside the map but past the frame count
    set_frame_count(13'd32);
    issue(OP_ALLOC, '0, 1'b0, 1'b0);
    issue(OP_FREE, 12'd40, 1'b0, 1'b0);
    // Frame count above the map size is clamped
    set_frame_count(13'd8191);
    issue(OP_ALLOC, '0, 1'b1, 1'b1);
    issue(OP_FREE, '0, 1'b0, 1'b0);
    issue(OP_ALLOC, '0, 1'b0, 1'b1);

    // Random phases, one frame count each; the last one runs without idling
    phase_counts[6] = COUNT_W'($urandom_range(32, 4096));
    for (int p = 0; p < PHASES; p++) begin
      set_frame_count(phase_counts[p]);
      for (int n = 0; n < BEATS_PER_PHASE; n++) begin
        // Leave stretches with back-to-back beats between idling stretches
        idling_on = (p != PHASES - 1) && ((n % 64) < 40);
        if (p == 2 && n == BEATS_PER_PHASE / 2) drain();
        random_beat();
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (fails == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/bfa_pkg.sv
rtl/bfa_ctrl.sv
rtl/bfa_datapath.sv
rtl/bitmap_frame_allocator.sv
tb/frame_alloc_check.sv
tb/tb_top.sv
